>>> sv/bit_array_store_with_range_extract_defines.svh
// Assertion macros for the bit array store with range extract.
// Included by files that check their own logic; needs clk and arst_n in scope.
`ifndef BIT_ARRAY_STORE_WITH_RANGE_EXTRACT_DEFINES_SVH
`define BIT_ARRAY_STORE_WITH_RANGE_EXTRACT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BITX_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BITX_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/bitx_pkg.sv
// Shared types and constants for the bit array store with range extract.
// No dependencies; used by the interfaces and every module of the block.
package bitx_pkg;

	localparam int MAX_BITS  = 1024;
	localparam int WORD_BITS = 64;
	localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	localparam int OP_W   = 2;
	localparam int POS_W  = 10;
	localparam int WNUM_W = 4;
	localparam int LEN_W  = 11;
	localparam int OFF_W  = $clog2(WORD_BITS);
	localparam int WIDX_W = POS_W - OFF_W;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_VECTOR_LENGTH = REG_IDX_W'(0);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	localparam logic [OP_W-1:0] OP_SET     = 2'd0;
	localparam logic [OP_W-1:0] OP_GET     = 2'd1;
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;
	localparam logic [OP_W-1:0] OP_AND     = 2'd3;

	typedef enum logic [2:0] {
		K_SET,
		K_GET,
		K_EXTRACT,
		K_AND,
		K_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_EXEC
	} bstate_t;

	typedef struct packed {
		kind_t                 kind;
		logic [WIDX_W-1:0]     widx;
		logic [OFF_W-1:0]      boff;
		logic [WIDX_W-1:0]     nwords_m1;
		logic [OFF_W-1:0]      last_m1;
		logic [WORD_BITS-1:0]  mask;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

endpackage

>>> sv/bitx_ifs.sv
// Valid/ready channel interfaces for requests and results of the bit array store.
// Depends on bitx_pkg for field widths.
interface bitx_req_if;
	logic                            valid;
	logic                            ready;
	logic [bitx_pkg::OP_W-1:0]       op;
	logic [bitx_pkg::POS_W-1:0]      bit_position;
	logic [bitx_pkg::POS_W-1:0]      range_end;
	logic [bitx_pkg::WNUM_W-1:0]     word_number;
	logic [bitx_pkg::WORD_BITS-1:0]  mask_word;

	modport source (output valid, op, bit_position, range_end, word_number, mask_word,
		input ready);
	modport sink (input valid, op, bit_position, range_end, word_number, mask_word,
		output ready);
endinterface

interface bitx_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            bit_value;
	logic [bitx_pkg::WORD_BITS-1:0]  data_word;
	logic                            last_word;
	logic                            error_flag;

	modport source (output valid, bit_value, data_word, last_word, error_flag,
		input ready);
	modport sink (input valid, bit_value, data_word, last_word, error_flag,
		output ready);
endinterface

>>> sv/bit_array_store_with_range_extract.sv
// Top level of the bit array store with range extract: length register on an
// APB-style port, front end, command queue and back end. Depends on bitx_pkg,
// the channel interfaces and bit_array_store_with_range_extract_defines.svh.
//
//   port group  kind          carries
//   req         valid/ready   op, bit_position, range_end, word_number, mask_word
//   rsp         valid/ready   bit_value, data_word, last_word, error_flag
//   apb         psel/penable  vector_length at byte address 0
//
// The front takes a request every cycle while the two-entry queue has room.
// The back reads memory for each set, get, and-word or refused request while
// taking it from the queue, then executes it; each further extract word goes
// back through a read step, as it needs a fresh read of a pair of stored words.
// Reset sets the length to 1024 and clears the word valid bits at once; no
// clearing pass is needed. A stalled result channel holds the back in its
// execute step while the front keeps filling the queue.
`include "bit_array_store_with_range_extract_defines.svh"

module bit_array_store_with_range_extract (
	input  logic                           clk,
	input  logic                           arst_n,
	bitx_req_if.sink                       req,
	bitx_rsp_if.source                     rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bitx_pkg::PADDR_W-1:0]   paddr,
	input  logic [bitx_pkg::PDATA_W-1:0]   pwdata,
	output logic [bitx_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	logic [bitx_pkg::LEN_W-1:0]     vl_q;
	logic [bitx_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           len_wr;
	logic                           push;
	logic                           pop;
	bitx_pkg::cmd_t                 push_cmd;
	bitx_pkg::cmd_t                 head;
	bitx_pkg::qstat_t               qstat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[bitx_pkg::PADDR_W-1:2];
	assign len_wr  = psel && penable && pwrite && pready
		&& (reg_idx == bitx_pkg::REG_VECTOR_LENGTH);
	assign prdata  = (reg_idx == bitx_pkg::REG_VECTOR_LENGTH)
		? bitx_pkg::PDATA_W'(vl_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q <= bitx_pkg::LEN_RESET;
		end else if (len_wr) begin
			vl_q <= pwdata[bitx_pkg::LEN_W-1:0];
		end
	end

	bitx_front u_front (
		.req      (req),
		.len      (vl_q),
		.qstat    (qstat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	bitx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.stat     (qstat),
		.head     (head)
	);

	bitx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

	`BITX_ASSERT_NXT(a_len_write, len_wr, vl_q == $past(pwdata[bitx_pkg::LEN_W-1:0]), "length register did not take the written value")
	`BITX_ASSERT_IMP(a_err_clean, rsp.valid && rsp.error_flag, (rsp.data_word == '0) && rsp.last_word && !rsp.bit_value, "refused request gave a result with payload")
	`BITX_ASSERT_IMP(a_get_single, rsp.valid && rsp.bit_value, rsp.last_word && !rsp.error_flag && (rsp.data_word == '0), "get result is not a clean single result")

endmodule

>>> sv/bitx_queue.sv
// Two-entry command queue between the front and back of the bit array store.
// Depends on bitx_pkg for the command type and depth.
module bitx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bitx_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output bitx_pkg::qstat_t stat,
	output bitx_pkg::cmd_t  head
);

	bitx_pkg::cmd_t                  entry_q [bitx_pkg::QDEPTH];
	logic [bitx_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [bitx_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [bitx_pkg::QCNT_W-1:0]     count_q;

	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == bitx_pkg::QCNT_W'(bitx_pkg::QDEPTH));
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> sv/bitx_front.sv
// Front end: takes requests, checks them against the configured length and
// turns each into a command for the queue. Depends on bitx_pkg and bitx_req_if.
module bitx_front (
	bitx_req_if.sink                    req,
	input  logic [bitx_pkg::LEN_W-1:0]  len,
	input  bitx_pkg::qstat_t            qstat,
	output logic                        push,
	output bitx_pkg::cmd_t              push_cmd
);

	logic [bitx_pkg::LEN_W-1:0] len_eff;
	logic [bitx_pkg::POS_W-1:0] diff;
	logic                       pos_bad;
	logic                       range_bad;
	logic                       word_bad;

	assign req.ready = !qstat.full;
	assign push      = req.valid && !qstat.full;

	always_comb begin
		if (32'(len) > bitx_pkg::MAX_BITS) begin
			len_eff = bitx_pkg::LEN_W'(bitx_pkg::MAX_BITS);
		end else begin
			len_eff = len;
		end
		diff      = req.range_end - req.bit_position;
		pos_bad   = ({1'b0, req.bit_position} >= len_eff)
			|| (32'(req.bit_position[bitx_pkg::POS_W-1:bitx_pkg::OFF_W])
				>= bitx_pkg::NUM_WORDS);
		range_bad = (req.bit_position > req.range_end)
			|| ({1'b0, req.range_end} >= len_eff);
		// The first bit of the target word must lie inside the used length.
		word_bad  = (32'(req.word_number) >= bitx_pkg::NUM_WORDS)
			|| (bitx_pkg::LEN_W'({req.word_number, {bitx_pkg::OFF_W{1'b0}}}) >= len_eff);
	end

	always_comb begin
		push_cmd.kind      = bitx_pkg::K_ERROR;
		push_cmd.widx      = req.bit_position[bitx_pkg::POS_W-1:bitx_pkg::OFF_W];
		push_cmd.boff      = req.bit_position[bitx_pkg::OFF_W-1:0];
		push_cmd.nwords_m1 = diff[bitx_pkg::POS_W-1:bitx_pkg::OFF_W];
		push_cmd.last_m1   = diff[bitx_pkg::OFF_W-1:0];
		push_cmd.mask      = req.mask_word;
		unique case (req.op)
			bitx_pkg::OP_SET: begin
				if (!pos_bad) begin
					push_cmd.kind = bitx_pkg::K_SET;
				end
			end
			bitx_pkg::OP_GET: begin
				if (!pos_bad) begin
					push_cmd.kind = bitx_pkg::K_GET;
				end
			end
			bitx_pkg::OP_EXTRACT: begin
				if (!range_bad) begin
					push_cmd.kind = bitx_pkg::K_EXTRACT;
				end
			end
			bitx_pkg::OP_AND: begin
				push_cmd.widx = bitx_pkg::WIDX_W'(req.word_number);
				if (!word_bad) begin
					push_cmd.kind = bitx_pkg::K_AND;
				end
			end
			default: begin
				push_cmd.kind = bitx_pkg::K_ERROR;
			end
		endcase
	end

endmodule

>>> sv/bitx_back.sv
// Back end: holds the word memory, runs one command at a time and drives the
// registered result channel. Depends on bitx_pkg and bitx_rsp_if.
module bitx_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bitx_pkg::qstat_t qstat,
	input  bitx_pkg::cmd_t   head,
	output logic             pop,
	bitx_rsp_if.source       rsp
);

	logic [bitx_pkg::WORD_BITS-1:0] mem_q [bitx_pkg::NUM_WORDS];
	logic [bitx_pkg::NUM_WORDS-1:0] word_vld_q;

	bitx_pkg::bstate_t              state_q;
	bitx_pkg::bstate_t              state_d;
	bitx_pkg::cmd_t                 cur_q;
	logic [bitx_pkg::WIDX_W-1:0]    widx_q;
	logic [bitx_pkg::WIDX_W-1:0]    cnt_q;

	logic [bitx_pkg::WORD_BITS-1:0] rdata_a_q;
	logic [bitx_pkg::WORD_BITS-1:0] rdata_b_q;
	logic                           ok_a_q;
	logic                           ok_b_q;

	logic                           out_vld_q;
	logic                           out_bit_q;
	logic [bitx_pkg::WORD_BITS-1:0] out_data_q;
	logic                           out_last_q;
	logic                           out_err_q;

	logic                           out_free;
	logic                           rd_en;
	logic [bitx_pkg::WIDX_W-1:0]    rd_idx;
	logic [bitx_pkg::WIDX_W:0]      rd_idx_b;
	logic                           load;
	logic                           mem_we;

	logic [bitx_pkg::WORD_BITS-1:0]   word_a;
	logic [bitx_pkg::WORD_BITS-1:0]   word_b;
	logic [2*bitx_pkg::WORD_BITS-1:0] pair;
	logic [bitx_pkg::WORD_BITS-1:0]   last_mask;
	logic                             at_last;
	logic                             res_last;
	logic                             res_bit;
	logic                             res_err;
	logic [bitx_pkg::WORD_BITS-1:0]   res_data;
	logic [bitx_pkg::WORD_BITS-1:0]   wr_data;

	assign out_free = !out_vld_q || rsp.ready;
	assign rd_idx_b = {1'b0, rd_idx} + 1'b1;

	// Control outputs of the sequencer.
	always_comb begin
		pop    = 1'b0;
		rd_en  = 1'b0;
		rd_idx = widx_q;
		load   = 1'b0;
		mem_we = 1'b0;
		unique case (state_q)
			bitx_pkg::B_IDLE: begin
				rd_idx = head.widx;
				if (qstat.valid) begin
					pop   = 1'b1;
					rd_en = 1'b1;
				end
			end
			bitx_pkg::B_READ: begin
				rd_en = 1'b1;
			end
			bitx_pkg::B_EXEC: begin
				if (out_free) begin
					load   = 1'b1;
					mem_we = (cur_q.kind == bitx_pkg::K_SET) || (cur_q.kind == bitx_pkg::K_AND);
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bitx_pkg::B_IDLE: begin
				if (qstat.valid) begin
					state_d = bitx_pkg::B_EXEC;
				end
			end
			bitx_pkg::B_READ: begin
				state_d = bitx_pkg::B_EXEC;
			end
			bitx_pkg::B_EXEC: begin
				if (out_free) begin
					state_d = res_last ? bitx_pkg::B_IDLE : bitx_pkg::B_READ;
				end
			end
			default: begin
				state_d = bitx_pkg::B_IDLE;
			end
		endcase
	end

	// Result datapath: words that were never written read as zero.
	always_comb begin
		word_a    = ok_a_q ? rdata_a_q : '0;
		word_b    = ok_b_q ? rdata_b_q : '0;
		pair      = {word_b, word_a} >> cur_q.boff;
		last_mask = {bitx_pkg::WORD_BITS{1'b1}}
			>> (bitx_pkg::OFF_W'(bitx_pkg::WORD_BITS - 1) - cur_q.last_m1);
		at_last   = (cnt_q == cur_q.nwords_m1);
		res_last  = (cur_q.kind != bitx_pkg::K_EXTRACT) || at_last;
		res_err   = (cur_q.kind == bitx_pkg::K_ERROR);
		res_bit   = (cur_q.kind == bitx_pkg::K_GET) ? word_a[cur_q.boff] : 1'b0;
		res_data  = '0;
		if (cur_q.kind == bitx_pkg::K_EXTRACT) begin
			res_data = pair[bitx_pkg::WORD_BITS-1:0]
				& (at_last ? last_mask : {bitx_pkg::WORD_BITS{1'b1}});
		end
		if (cur_q.kind == bitx_pkg::K_SET) begin
			wr_data = word_a | (bitx_pkg::WORD_BITS'(1) << cur_q.boff);
		end else begin
			wr_data = word_a & cur_q.mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bitx_pkg::B_IDLE;
			word_vld_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				word_vld_q[bitx_pkg::ADDR_W'(widx_q)] <= 1'b1;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[bitx_pkg::ADDR_W'(widx_q)] <= wr_data;
		end
		if (rd_en) begin
			rdata_a_q <= mem_q[bitx_pkg::ADDR_W'(rd_idx)];
			rdata_b_q <= mem_q[bitx_pkg::ADDR_W'(rd_idx_b)];
			ok_a_q    <= (32'(rd_idx) < bitx_pkg::NUM_WORDS)
				&& word_vld_q[bitx_pkg::ADDR_W'(rd_idx)];
			ok_b_q    <= (32'(rd_idx_b) < bitx_pkg::NUM_WORDS)
				&& word_vld_q[bitx_pkg::ADDR_W'(rd_idx_b)];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= head;
			widx_q <= head.widx;
			cnt_q  <= '0;
		end else if (load && !res_last) begin
			widx_q <= widx_q + 1'b1;
			cnt_q  <= cnt_q + 1'b1;
		end
		if (load) begin
			out_bit_q  <= res_bit;
			out_data_q <= res_data;
			out_last_q <= res_last;
			out_err_q  <= res_err;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.bit_value  = out_bit_q;
	assign rsp.data_word  = out_data_q;
	assign rsp.last_word  = out_last_q;
	assign rsp.error_flag = out_err_q;

endmodule

>>> tb/bit_array_store_with_range_extract_checker.sv
// Result checker for the bit array store with range extract: watches the request,
// result and configuration ports, predicts every result and compares in order.
// Depends on bitx_pkg and the channel interfaces in bitx_ifs.sv.
module bit_array_store_with_range_extract_checker
	import bitx_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	bitx_req_if                 req,
	bitx_rsp_if                 rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic                pready,
	output int                  errors,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                  bit_value;
		logic [WORD_BITS-1:0]  data_word;
		logic                  last_word;
		logic                  error_flag;
	} result_t;

	logic [WORD_BITS-1:0] bit_store [NUM_WORDS];
	logic [LEN_W-1:0]     length_reg;
	result_t              predicted_results [$];
	int                   mismatches;

	function automatic logic [WORD_BITS-1:0] stored_word(int idx);
		return (idx < NUM_WORDS) ? bit_store[idx] : '0;
	endfunction

	function automatic void queue_result(logic b, logic [WORD_BITS-1:0] d, logic l, logic e);
		result_t r;
		r.bit_value  = b;
		r.data_word  = d;
		r.last_word  = l;
		r.error_flag = e;
		predicted_results.push_back(r);
	endfunction

	// Applies one request to the local copy of the store and queues its results.
	function automatic void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic [POS_W-1:0] last_pos, logic [WNUM_W-1:0] wn, logic [WORD_BITS-1:0] mask);
		int                   len;
		int                   remaining;
		int                   off;
		int                   w;
		int                   take;
		int                   k;
		logic [WORD_BITS-1:0] v;
		len = (int'(length_reg) < MAX_BITS) ? int'(length_reg) : MAX_BITS;
		off = int'(pos) % WORD_BITS;
		w = int'(pos) / WORD_BITS;
		case (op)
			OP_SET, OP_GET: begin
				if (int'(pos) >= len || w >= NUM_WORDS) begin
					queue_result(1'b0, '0, 1'b1, 1'b1);
				end else if (op == OP_SET) begin
					bit_store[w][off] = 1'b1;
					queue_result(1'b0, '0, 1'b1, 1'b0);
				end else begin
					queue_result(bit_store[w][off], '0, 1'b1, 1'b0);
				end
			end
			OP_AND: begin
				if (int'(wn) >= NUM_WORDS || int'(wn) * WORD_BITS >= len) begin
					queue_result(1'b0, '0, 1'b1, 1'b1);
				end else begin
					bit_store[wn] = bit_store[wn] & mask;
					queue_result(1'b0, '0, 1'b1, 1'b0);
				end
			end
			default: begin
				if (pos > last_pos || int'(last_pos) >= len) begin
					queue_result(1'b0, '0, 1'b1, 1'b1);
				end else begin
					remaining = int'(last_pos) - int'(pos) + 1;
					k = 0;
					while (remaining > 0 && k < 16) begin
						v = stored_word(w) >> off;
						take = (remaining > WORD_BITS) ? WORD_BITS : remaining;
						// A word-aligned start takes nothing from the next stored word.
						if (off != 0)
							v = v | (stored_word(w + 1) << (WORD_BITS - off));
						if (take < WORD_BITS)
							v = v & ((64'd1 << take) - 64'd1);
						remaining = remaining - take;
						queue_result(1'b0, v, remaining == 0, 1'b0);
						k++;
						w++;
					end
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t head;
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++)
				bit_store[i] = '0;
			length_reg = LEN_RESET;
			predicted_results.delete();
			mismatches = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result arrived with no request waiting for it");
					mismatches++;
				end else begin
					head = predicted_results.pop_front();
					if (rsp.bit_value !== head.bit_value) begin
						$error("bit_value: expected %0d, got %0d", head.bit_value, rsp.bit_value);
						mismatches++;
					end
					if (rsp.data_word !== head.data_word) begin
						$error("data_word: expected %h, got %h", head.data_word, rsp.data_word);
						mismatches++;
					end
					if (rsp.last_word !== head.last_word) begin
						$error("last_word: expected %0d, got %0d", head.last_word, rsp.last_word);
						mismatches++;
					end
					if (rsp.error_flag !== head.error_flag) begin
						$error("error_flag: expected %0d, got %0d", head.error_flag,
							rsp.error_flag);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				apply_request(req.op, req.bit_position, req.range_end, req.word_number,
					req.mask_word);
			if (psel && penable && pwrite && pready && paddr == {REG_VECTOR_LENGTH, 2'b00})
				length_reg = pwdata[LEN_W-1:0];
			errors <= mismatches;
			outstanding <= predicted_results.size();
		end
	end

endmodule

>>> tb/bit_array_store_with_range_extract_test.sv
// Top of the bit array store testbench: clock, reset, request and length stimulus,
// random result stalls, a watchdog and the verdict. Depends on bitx_pkg, the
// channel interfaces, the block and bit_array_store_with_range_extract_checker.
module bit_array_store_with_range_extract_test;
	import bitx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT       = 21;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 40;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	bitx_req_if req_ch ();
	bitx_rsp_if rsp_ch ();

	int fail_count;
	int results_due;
	int quiet_cycles;
	int active_len;
	bit steady;

	bit_array_store_with_range_extract uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bit_array_store_with_range_extract_checker results_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.errors      (fail_count),
		.outstanding (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Ends the run when neither channel has moved anything for too long.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Valid stays high after a handshake so that back-to-back requests need no
	// second assignment in the same step; an idle cycle or wait_for_results lowers it.
	task automatic send_request(logic [OP_W-1:0] op, int pos, int last_pos, int wn,
			logic [WORD_BITS-1:0] mask);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= op;
		req_ch.bit_position <= POS_W'(pos);
		req_ch.range_end    <= POS_W'(last_pos);
		req_ch.word_number  <= WNUM_W'(wn);
		req_ch.mask_word    <= mask;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(int len);
		wait_for_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_VECTOR_LENGTH, 2'b00};
		pwdata  <= PDATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		active_len = len;
	endtask

	task automatic random_requests(int count);
		int                   lim;
		int                   pick;
		int                   start;
		int                   span;
		int                   room;
		bit                   wellformed;
		logic [OP_W-1:0]      op;
		int                   pos;
		int                   last_pos;
		int                   wn;
		logic [WORD_BITS-1:0] mask;
		lim = (active_len > MAX_BITS) ? MAX_BITS : active_len;
		repeat (count) begin
			pick = $urandom_range(9);
			op = (pick < 4) ? OP_SET : (pick < 6) ? OP_GET : (pick < 9) ? OP_EXTRACT : OP_AND;
			wellformed = ($urandom_range(99) < 80) && (lim > 0);
			pos = $urandom_range(1023);
			last_pos = $urandom_range(1023);
			wn = $urandom_range(15);
			mask = {$urandom, $urandom};
			// Mostly dense masks, so that and-word does not wipe the store.
			if ($urandom_range(3) != 0)
				mask = mask | {$urandom, $urandom};
			if (wellformed) begin
				case (op)
					OP_SET, OP_GET: pos = $urandom_range(lim - 1);
					OP_AND: wn = $urandom_range((lim - 1) / WORD_BITS);
					default: begin
						start = $urandom_range(lim - 1);
						room = lim - 1 - start;
						if ($urandom_range(9) == 0 || room < 150)
							span = $urandom_range(room);
						else
							span = $urandom_range(150);
						pos = start;
						last_pos = start + span;
					end
				endcase
			end
			send_request(op, pos, last_pos, wn, mask);
		end
	endtask

	initial begin
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.op           <= OP_SET;
		req_ch.bit_position <= '0;
		req_ch.range_end    <= '0;
		req_ch.word_number  <= '0;
		req_ch.mask_word    <= '0;
		steady              <= 1'b0;
		quiet_cycles        <= 0;
		active_len = int'(LEN_RESET);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset length.
		send_request(OP_SET, 0, 0, 0, '1);
		send_request(OP_SET, 1023, 0, 0, '1);
		send_request(OP_SET, 63, 0, 0, '1);
		send_request(OP_SET, 64, 0, 0, '1);
		send_request(OP_GET, 0, 0, 0, '0);
		send_request(OP_GET, 1023, 0, 0, '0);
		send_request(OP_GET, 1, 0, 0, '0);
		send_request(OP_EXTRACT, 0, 1023, 0, '0);
		send_request(OP_EXTRACT, 0, 0, 0, '0);
		send_request(OP_EXTRACT, 1023, 1023, 0, '0);
		send_request(OP_EXTRACT, 63, 64, 0, '0);
		send_request(OP_EXTRACT, 64, 127, 0, '0);
		send_request(OP_EXTRACT, 1, 65, 0, '0);
		send_request(OP_EXTRACT, 10, 9, 0, '0);
		send_request(OP_AND, 0, 0, 15, '1);
		send_request(OP_AND, 0, 0, 0, '0);
		send_request(OP_GET, 0, 0, 0, '0);
		send_request(OP_EXTRACT, 0, 127, 0, '0);
		send_request(OP_AND, 0, 0, 7, {$urandom, $urandom});
		send_request(OP_SET, 500, 0, 0, '1);

		write_length(2047);
		random_requests(50);

		// A shorter length leaves the bits set above it stored but out of reach.
		write_length(500);
		send_request(OP_SET, 500, 0, 0, '1);
		send_request(OP_GET, 1023, 0, 0, '1);
		send_request(OP_EXTRACT, 0, 500, 0, '1);
		send_request(OP_AND, 0, 0, 8, '1);
		send_request(OP_AND, 0, 0, 7, '1);
		random_requests(45);

		write_length(0);
		random_requests(10);
		write_length(1);
		random_requests(15);
		write_length(64);
		random_requests(40);

		write_length(1000);
		steady <= 1'b1;
		random_requests(50);
		steady <= 1'b0;

		write_length(int'(LEN_RESET));
		random_requests(25);

		wait_for_results();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
